// ----- sv/keyed_state_table_core_defines.svh -----
// Assertion macros for the keyed state table core.
`ifndef KEYED_STATE_TABLE_CORE_DEFINES_SVH
`define KEYED_STATE_TABLE_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled in reset.
`define KST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyed_state_table_core: assertion failed");
// Next-cycle implication, disabled in reset.
`define KST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyed_state_table_core: assertion failed");
`else
`define KST_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define KST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/kst_pkg.sv -----
// Shared types and constants for the keyed state table core.
`default_nettype none
package kst_pkg;

    localparam int KST_ENTRIES   = 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam int KEY_W         = 16;
    localparam int STATE_W       = 8;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 8;

    localparam logic [STATE_W-1:0] NONE_CODE_RESET    = 8'd0;
    localparam logic [STATE_W-1:0] STARTED_CODE_RESET = 8'd1;

    localparam logic [CFG_INDEX_W-1:0] CFG_NONE_CODE    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STARTED_CODE = 1'b1;

    typedef enum logic [1:0] {
        OP_QUERY  = 2'd0,
        OP_ADD    = 2'd1,
        OP_UPDATE = 2'd2,
        OP_REMOVE = 2'd3
    } kst_op_e_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } kst_status_e_t;

    typedef struct packed {
        kst_op_e_t            op;
        logic [KEY_W-1:0]     key;
        logic [STATE_W-1:0]   new_state;
    } kst_cmd_t;

    typedef struct packed {
        logic [STATE_W-1:0] none_code;
        logic [STATE_W-1:0] started_code;
    } kst_cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } kst_q_status_t;

endpackage
`default_nettype wire

// ----- sv/keyed_state_table_core.sv -----
// Keyed state table: a small associative table mapping 16-bit keys to state codes.
// Usage: an item word (action, key, new_state) enters on item_valid while item_stall
// is low; one result word (found_state, status) leaves on result_valid while
// result_stall is low, one result per item, in order.
// Actions: query, add, update, remove. found_state is the key's state before the
// action, or the none code if absent; status is done, ignored or table full.
// Path: a taken item passes the input register and the queue, then execution into
// the result register. Throughput: one item per cycle while result_stall is low,
// set by the parallel key compare and table write in the back stage.
// Configuration: cfg_write with cfg_index selects none code (0) or started code (1);
// write only while no item is in flight.
// Reset: table empty, none code 0, started code 1, no result pending.
// When the receiver stalls, the result register holds, the two-entry queue
// fills, then the input register, and item_stall rises.
`default_nettype none
`include "keyed_state_table_core_defines.svh"
module keyed_state_table_core
    import kst_pkg::*;
#(
    parameter int ENTRIES = KST_ENTRIES
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     item_valid,
    output logic                          item_stall,
    input  wire logic [1:0]               action,
    input  wire logic [KEY_W-1:0]         key,
    input  wire logic [STATE_W-1:0]       new_state,
    output logic                          result_valid,
    input  wire logic                     result_stall,
    output logic [STATE_W-1:0]            found_state,
    output logic [1:0]                    status,
    input  wire logic                     cfg_write,
    input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

    logic [STATE_W-1:0] none_code_reg, none_code_next;
    logic [STATE_W-1:0] started_code_reg, started_code_next;
    kst_cfg_t           cfg;
    kst_q_status_t      q_stat;
    kst_cmd_t           push_cmd;
    kst_cmd_t           head_cmd;
    logic               push;
    logic               pop;

    always_comb
    begin
        none_code_next    = none_code_reg;
        started_code_next = started_code_reg;
        if (cfg_write)
        begin
            if (cfg_index == CFG_NONE_CODE)
                none_code_next = cfg_data;
            if (cfg_index == CFG_STARTED_CODE)
                started_code_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            none_code_reg    <= NONE_CODE_RESET;
            started_code_reg <= STARTED_CODE_RESET;
        end
        else
        begin
            none_code_reg    <= none_code_next;
            started_code_reg <= started_code_next;
        end
    end

    assign cfg.none_code    = none_code_reg;
    assign cfg.started_code = started_code_reg;

    kst_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .action     (action),
        .key        (key),
        .new_state  (new_state),
        .q_stat     (q_stat),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    kst_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    kst_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_stat       (q_stat),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .found_state  (found_state),
        .status       (status)
    );

    `KST_ASSERT_NEXT(a_pop_loads_result, clk, rst_n, pop, result_valid)
    `KST_ASSERT_NOW(a_no_pop_when_empty, clk, rst_n, q_stat.empty, !pop)
    `KST_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, item_stall, q_stat.full)

endmodule
`default_nettype wire

// ----- sv/kst_queue.sv -----
// Short command queue between the front and back parts.
`default_nettype none
module kst_queue
    import kst_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  kst_cmd_t           push_cmd,
    input  wire logic          pop,
    output kst_cmd_t           head_cmd,
    output kst_q_status_t      q_stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    kst_cmd_t               mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    assign head_cmd     = mem[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule
`default_nettype wire

// ----- sv/kst_front.sv -----
// Input stage: takes words, decodes the action and feeds the queue.
`default_nettype none
module kst_front
    import kst_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire logic [1:0]           action,
    input  wire logic [KEY_W-1:0]     key,
    input  wire logic [STATE_W-1:0]   new_state,
    input  kst_q_status_t             q_stat,
    output logic                      push,
    output kst_cmd_t                  push_cmd
);

    logic       valid_reg, valid_next;
    kst_cmd_t   cmd_reg, cmd_next;
    logic       accept;

    always_comb
    begin
        push       = valid_reg && !q_stat.full;
        item_stall = valid_reg && q_stat.full;
        accept     = item_valid && !item_stall;
        cmd_next.op        = kst_op_e_t'(action);
        cmd_next.key       = key;
        cmd_next.new_state = new_state;
        if (accept)
            valid_next = 1'b1;
        else if (push)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd_next;
    end

    assign push_cmd = cmd_reg;

endmodule
`default_nettype wire

// ----- sv/kst_back.sv -----
// Execution stage: key table, parallel lookup, update and result register.
`default_nettype none
module kst_back
    import kst_pkg::*;
#(
    parameter int ENTRIES = KST_ENTRIES
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  kst_cfg_t                  cfg,
    input  kst_q_status_t             q_stat,
    input  kst_cmd_t                  head_cmd,
    output logic                      pop,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output logic [STATE_W-1:0]        found_state,
    output logic [1:0]                status
);

    logic [ENTRIES-1:0]     valid_reg, valid_next;
    logic [KEY_W-1:0]       key_mem   [ENTRIES];
    logic [STATE_W-1:0]     state_mem [ENTRIES];

    logic [ENTRIES-1:0]     hit_vec;
    logic [ENTRIES-1:0]     free_vec;
    logic [ENTRIES-1:0]     first_free;
    logic [ENTRIES-1:0]     st_we;
    logic [ENTRIES-1:0]     alloc_vec;
    logic [ENTRIES-1:0]     clr_vec;
    logic [STATE_W-1:0]     hit_state;
    logic [STATE_W-1:0]     found;
    logic [STATE_W-1:0]     st_wdata;
    logic                   hit_any;
    logic                   free_any;
    logic                   found_none;
    kst_status_e_t          stat;

    logic                   rv_reg, rv_next;
    logic [STATE_W-1:0]     found_reg;
    kst_status_e_t          status_reg;

    // keys are unique in the table, so at most one hit bit is set
    always_comb
    begin
        hit_state = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i] = valid_reg[i] && (key_mem[i] == head_cmd.key);
            hit_state  = hit_state | (hit_vec[i] ? state_mem[i] : '0);
        end
        free_vec   = ~valid_reg;
        first_free = free_vec & (~free_vec + ENTRIES'(1));
        hit_any    = |hit_vec;
        free_any   = |free_vec;
        found      = hit_any ? hit_state : cfg.none_code;
        found_none = (found == cfg.none_code);
    end

    always_comb
    begin
        pop       = !q_stat.empty && (!rv_reg || !result_stall);
        stat      = ST_DONE;
        st_we     = '0;
        alloc_vec = '0;
        clr_vec   = '0;
        st_wdata  = head_cmd.new_state;
        unique case (head_cmd.op)
            OP_QUERY:
            begin
                stat = ST_DONE;
            end
            OP_ADD:
            begin
                st_wdata = cfg.started_code;
                if (!found_none)
                    stat = ST_IGNORED;
                else if (hit_any)
                    st_we = hit_vec;
                else if (free_any)
                begin
                    st_we     = first_free;
                    alloc_vec = first_free;
                end
                else
                    stat = ST_FULL;
            end
            OP_UPDATE:
            begin
                if (!hit_any || found_none)
                    stat = ST_IGNORED;
                else
                    st_we = hit_vec;
            end
            OP_REMOVE:
            begin
                if (!hit_any || found_none)
                    stat = ST_IGNORED;
                else
                    clr_vec = hit_vec;
            end
            default:
            begin
                stat = ST_DONE;
            end
        endcase
        if (!pop)
        begin
            st_we     = '0;
            alloc_vec = '0;
            clr_vec   = '0;
        end
        valid_next = (valid_reg | alloc_vec) & ~clr_vec;
        if (pop)
            rv_next = 1'b1;
        else if (!result_stall)
            rv_next = 1'b0;
        else
            rv_next = rv_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (alloc_vec[i])
                key_mem[i] <= head_cmd.key;
            if (st_we[i])
                state_mem[i] <= st_wdata;
        end
        if (pop)
        begin
            found_reg  <= found;
            status_reg <= stat;
        end
    end

    assign result_valid = rv_reg;
    assign found_state  = found_reg;
    assign status       = status_reg;

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for keyed_state_table_core: a directed table, then random phases checked by a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kst_pkg::*;

    typedef struct {
        logic [STATE_W-1:0] found;
        kst_status_e_t      stat;
    } outcome_t;

    typedef struct {
        kst_op_e_t          op;
        logic [KEY_W-1:0]   k;
        logic [STATE_W-1:0] ns;
        bit                 typed;
        logic [STATE_W-1:0] found;
        kst_status_e_t      stat;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   item_valid = 1'b0;
    logic                   item_stall;
    logic [1:0]             action = OP_QUERY;
    logic [KEY_W-1:0]       key = '0;
    logic [STATE_W-1:0]     new_state = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic [STATE_W-1:0]     found_state;
    logic [1:0]             status;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_NONE_CODE;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor copy of the table and its codes
    bit                 tbl_used [KST_ENTRIES];
    logic [KEY_W-1:0]   tbl_key [KST_ENTRIES];
    logic [STATE_W-1:0] tbl_state [KST_ENTRIES];
    logic [STATE_W-1:0] cur_none = NONE_CODE_RESET;
    logic [STATE_W-1:0] cur_started = STARTED_CODE_RESET;

    outcome_t pending_q[$];
    bit quiet = 1'b0;
    int err_count = 0;
    int n_items = 0;
    int n_results = 0;
    int n_done = 0;
    int n_ignored = 0;
    int n_full = 0;
    int n_settings = 1;

    keyed_state_table_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .key          (key),
        .new_state    (new_state),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .found_state  (found_state),
        .status       (status),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic outcome_t apply_action(kst_op_e_t op, logic [KEY_W-1:0] k,
                                              logic [STATE_W-1:0] ns);
        int hit;
        int free_slot;
        outcome_t r;
        hit = -1;
        free_slot = -1;
        for (int i = 0; i < KST_ENTRIES; i++)
        begin
            if (tbl_used[i])
            begin
                if (hit < 0 && tbl_key[i] == k)
                    hit = i;
            end
            else if (free_slot < 0)
                free_slot = i;
        end
        r.found = (hit >= 0) ? tbl_state[hit] : cur_none;
        r.stat = ST_DONE;
        case (op)
            OP_ADD:
            begin
                if (r.found != cur_none)
                    r.stat = ST_IGNORED;
                else if (hit >= 0)
                    tbl_state[hit] = cur_started;
                else if (free_slot >= 0)
                begin
                    tbl_used[free_slot] = 1'b1;
                    tbl_key[free_slot] = k;
                    tbl_state[free_slot] = cur_started;
                end
                else
                    r.stat = ST_FULL;
            end
            OP_UPDATE:
            begin
                if (hit < 0 || r.found == cur_none)
                    r.stat = ST_IGNORED;
                else
                    tbl_state[hit] = ns;
            end
            OP_REMOVE:
            begin
                if (hit < 0 || r.found == cur_none)
                    r.stat = ST_IGNORED;
                else
                    tbl_used[hit] = 1'b0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic dir_row_t mk_row(kst_op_e_t op, logic [KEY_W-1:0] k,
                                        logic [STATE_W-1:0] ns, bit typed,
                                        logic [STATE_W-1:0] found, kst_status_e_t stat);
        dir_row_t r;
        r.op = op;
        r.k = k;
        r.ns = ns;
        r.typed = typed;
        r.found = found;
        r.stat = stat;
        return r;
    endfunction

    // leaves item_valid high after acceptance; caller drives it again in the same step
    task automatic send_word(kst_op_e_t op, logic [KEY_W-1:0] k, logic [STATE_W-1:0] ns,
                             bit typed, logic [STATE_W-1:0] found, kst_status_e_t stat);
        outcome_t predicted;
        outcome_t typed_out;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        item_valid <= 1'b1;
        action <= op;
        key <= k;
        new_state <= ns;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predicted = apply_action(op, k, ns);
        typed_out.found = found;
        typed_out.stat = stat;
        pending_q.push_back(typed ? typed_out : predicted);
        n_items++;
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_codes(logic [STATE_W-1:0] nc, logic [STATE_W-1:0] sc);
        cfg_write <= 1'b1;
        cfg_index <= CFG_NONE_CODE;
        cfg_data <= nc;
        @(posedge clk);
        cur_none = nc;
        cfg_index <= CFG_STARTED_CODE;
        cfg_data <= sc;
        @(posedge clk);
        cur_started = sc;
        cfg_write <= 1'b0;
        n_settings++;
    endtask

    // result side: random stall bursts and in-order check
    initial
    begin
        int hold;
        outcome_t exp_w;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                if (pending_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected result word: found_state=%02h status=%0d",
                                 found_state, status);
                end
                else
                begin
                    exp_w = pending_q.pop_front();
                    n_results++;
                    case (exp_w.stat)
                        ST_DONE:    n_done++;
                        ST_IGNORED: n_ignored++;
                        default:    n_full++;
                    endcase
                    if (found_state !== exp_w.found || status !== exp_w.stat)
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display("result %0d mismatch: expected found_state=%02h status=%0d, got found_state=%02h status=%0d",
                                     n_results, exp_w.found, exp_w.stat, found_state, status);
                    end
                end
            end
            if (hold > 0)
                hold--;
            else if (!quiet && $urandom_range(0, 6) == 0)
                hold = $urandom_range(1, 8);
            result_stall <= (hold > 0);
        end
    end

    initial
    begin
        dir_row_t rows[$];
        logic [KEY_W-1:0] pool[$];
        logic [STATE_W-1:0] nc;
        logic [STATE_W-1:0] sc;
        logic [KEY_W-1:0] k;
        logic [STATE_W-1:0] ns;
        kst_op_e_t op;
        int cnt;
        int pool_n;
        int pick;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        rows.push_back(mk_row(OP_QUERY,  16'h0000, 8'h00, 1, 8'h00, ST_DONE));
        rows.push_back(mk_row(OP_UPDATE, 16'h0005, 8'hFF, 1, 8'h00, ST_IGNORED));
        rows.push_back(mk_row(OP_REMOVE, 16'hFFFF, 8'h00, 1, 8'h00, ST_IGNORED));
        rows.push_back(mk_row(OP_ADD,    16'h0000, 8'h00, 1, 8'h00, ST_DONE));
        rows.push_back(mk_row(OP_ADD,    16'h0000, 8'h00, 1, 8'h01, ST_IGNORED));
        // update writes the none code to the key: then update and remove are refused, add reuses it
        rows.push_back(mk_row(OP_UPDATE, 16'h0000, 8'h00, 1, 8'h01, ST_DONE));
        rows.push_back(mk_row(OP_REMOVE, 16'h0000, 8'h00, 0, 8'h00, ST_DONE));
        rows.push_back(mk_row(OP_UPDATE, 16'h0000, 8'h7E, 0, 8'h00, ST_DONE));
        rows.push_back(mk_row(OP_ADD,    16'h0000, 8'h00, 1, 8'h00, ST_DONE));
        rows.push_back(mk_row(OP_UPDATE, 16'h0000, 8'hFF, 1, 8'h01, ST_DONE));
        rows.push_back(mk_row(OP_QUERY,  16'h0000, 8'h00, 1, 8'hFF, ST_DONE));
        for (int i = 0; i < KST_ENTRIES - 1; i++)
            rows.push_back(mk_row(OP_ADD, (i == 0) ? 16'hFFFF : 16'(i), 8'h00, 1,
                                  8'h00, ST_DONE));
        rows.push_back(mk_row(OP_ADD,    16'hABCD, 8'h00, 1, 8'h00, ST_FULL));
        rows.push_back(mk_row(OP_REMOVE, 16'h0000, 8'h00, 1, 8'hFF, ST_DONE));
        rows.push_back(mk_row(OP_ADD,    16'hABCD, 8'h00, 0, 8'h00, ST_DONE));

        for (int i = 0; i < rows.size(); i++)
            send_word(rows[i].op, rows[i].k, rows[i].ns, rows[i].typed,
                      rows[i].found, rows[i].stat);

        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0:
                begin
                    nc = 8'hFF; sc = 8'h00; cnt = 180; pool_n = 40;
                end
                1:
                begin
                    nc = 8'h00; sc = 8'hFF; cnt = 180; pool_n = 6;
                end
                2:
                begin
                    nc = 8'h55; sc = 8'h55; cnt = 150; pool_n = 20;
                end
                3, 4:
                begin
                    nc = 8'($urandom_range(0, 255));
                    sc = 8'($urandom_range(0, 255));
                    cnt = 160;
                    pool_n = $urandom_range(4, 40);
                end
                5:
                begin
                    nc = 8'($urandom_range(0, 255));
                    sc = 8'($urandom_range(0, 255));
                    cnt = 170;
                    pool_n = 24;
                end
                default:
                begin
                    nc = NONE_CODE_RESET; sc = STARTED_CODE_RESET; cnt = 150; pool_n = 24;
                end
            endcase
            wait_idle();
            write_codes(nc, sc);
            quiet = (p == 6);
            pool.delete();
            for (int j = 0; j < pool_n; j++)
                pool.push_back(16'($urandom_range(0, 65535)));
            for (int n = 0; n < cnt; n++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    op = OP_ADD;
                else if (pick < 6)
                    op = OP_QUERY;
                else if (pick < 8)
                    op = OP_UPDATE;
                else
                    op = OP_REMOVE;
                if ($urandom_range(0, 9) == 0)
                    k = 16'($urandom_range(0, 65535));
                else
                    k = pool[$urandom_range(0, pool_n - 1)];
                pick = $urandom_range(0, 7);
                if (pick < 2)
                    ns = cur_none;
                else if (pick == 2)
                    ns = cur_started;
                else
                    ns = 8'($urandom_range(0, 255));
                if (!quiet && $urandom_range(0, 149) == 0)
                    wait_idle();
                send_word(op, k, ns, 0, 8'h00, ST_DONE);
            end
        end

        wait_idle();
        $display("Covered %0d items and %0d result words over %0d code settings",
                 n_items, n_results, n_settings);
        $display("Outcomes: %0d done, %0d ignored, %0d table full", n_done, n_ignored, n_full);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/kst_pkg.sv
sv/kst_queue.sv
sv/kst_front.sv
sv/kst_back.sv
sv/keyed_state_table_core.sv
dv/tb.sv
